// File: hdl/pf_pkg.sv
// shared types, constants and helpers of the playfair digraph cipher
package pf_pkg;

  localparam int unsigned GRID_SIDE = 5;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [GRID_SIDE-1:0][CODE_W-1:0] row_t;
  typedef row_t [GRID_SIDE-1:0] square_t;

  localparam code_t LETTER_I = code_t'(8);
  localparam code_t LETTER_J = code_t'(9);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ROW_0 = 3'd0,
    REG_KEY_ROW_1 = 3'd1,
    REG_KEY_ROW_2 = 3'd2,
    REG_KEY_ROW_3 = 3'd3,
    REG_KEY_ROW_4 = 3'd4,
    REG_DECRYPT   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } loc_t;

  typedef struct packed {
    code_t first_out;
    code_t second_out;
    logic  both_found;
  } result_t;

  function automatic idx_t step_idx(idx_t v, logic back);
    idx_t r;
    if (back) begin
      r = (v == '0) ? idx_t'(GRID_SIDE - 1) : idx_t'(v - idx_t'(1));
    end else begin
      r = (v == idx_t'(GRID_SIDE - 1)) ? '0 : idx_t'(v + idx_t'(1));
    end
    return r;
  endfunction

  function automatic code_t sq_cell(square_t sq, idx_t r, idx_t c);
    return sq[r][c];
  endfunction

endpackage

// File: hdl/pf_locate.sv
// one lookup lane: finds a letter in the key square, last match wins
module pf_locate import pf_pkg::*; (
  input  code_t   letter_i,
  input  square_t square_i,
  output loc_t    loc_o
);

  code_t key;

  assign key = (letter_i == LETTER_J) ? LETTER_I : letter_i;

  always_comb begin
    loc_o = '0;
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        if (square_i[r][c] == key) begin
          loc_o.found = 1'b1;
          loc_o.row   = idx_t'(r);
          loc_o.col   = idx_t'(c);
        end
      end
    end
  end

endmodule

// File: hdl/pf_merge.sv
// merge stage: combines both lane positions into the output letter pair
module pf_merge import pf_pkg::*; (
  input  code_t   raw_a_i,
  input  code_t   raw_b_i,
  input  loc_t    loc_a_i,
  input  loc_t    loc_b_i,
  input  square_t square_i,
  input  logic    back_i,
  output result_t res_o
);

  always_comb begin
    res_o.both_found = loc_a_i.found & loc_b_i.found;
    priority if (!(loc_a_i.found && loc_b_i.found)) begin
      res_o.first_out  = raw_a_i;
      res_o.second_out = raw_b_i;
    end else if (loc_a_i.row == loc_b_i.row) begin
      res_o.first_out  = sq_cell(square_i, loc_a_i.row, step_idx(loc_a_i.col, back_i));
      res_o.second_out = sq_cell(square_i, loc_b_i.row, step_idx(loc_b_i.col, back_i));
    end else if (loc_a_i.col == loc_b_i.col) begin
      res_o.first_out  = sq_cell(square_i, step_idx(loc_a_i.row, back_i), loc_a_i.col);
      res_o.second_out = sq_cell(square_i, step_idx(loc_b_i.row, back_i), loc_b_i.col);
    end else begin
      res_o.first_out  = sq_cell(square_i, loc_a_i.row, loc_b_i.col);
      res_o.second_out = sq_cell(square_i, loc_b_i.row, loc_a_i.col);
    end
  end

endmodule

// File: hdl/playfair_digraph_cipher.sv
// Playfair digraph cipher over a 5x5 key square written through the config port.
// Takes one digraph word per cycle while not stalled and returns one result word per
// digraph: the first stage runs two lookup lanes (one per letter, 25 parallel compares
// each) into a register, the second merges them into the output register. J is looked
// up as I; a letter missing from the square clears tuser and passes both input letters
// through unchanged. The user must write the key rows and the decrypt mode only while
// no digraph is in flight; the block does not enforce this. Writes always complete.
module playfair_digraph_cipher import pf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // first_letter[4:0], second_letter[9:5]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // first_out[4:0], second_out[9:5]
  output logic [0:0]           m_axis_tuser,   // both_found[0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GRID_SIDE*CODE_W-1:0] cfg_data_i
);

  square_t square_q;
  logic    back_q;

  logic    s1_valid_q, s1_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    s1_ready, s2_ready, in_acc;
  code_t   raw_a_q, raw_b_q;
  loc_t    loc_a_q, loc_b_q;
  loc_t    loc_a_d, loc_b_d;
  result_t res_d, res_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q <= '0;
      back_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KEY_ROW_0: square_q[0] <= row_t'(cfg_data_i);
        REG_KEY_ROW_1: square_q[1] <= row_t'(cfg_data_i);
        REG_KEY_ROW_2: square_q[2] <= row_t'(cfg_data_i);
        REG_KEY_ROW_3: square_q[3] <= row_t'(cfg_data_i);
        REG_KEY_ROW_4: square_q[4] <= row_t'(cfg_data_i);
        REG_DECRYPT:   back_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // two-stage pipe with per-stage ready
  assign s2_ready      = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign in_acc        = s_axis_tvalid && s1_ready;
  assign s1_valid_d    = s1_ready ? s_axis_tvalid : s1_valid_q;
  assign out_valid_d   = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  pf_locate u_lane_a (
    .letter_i (s_axis_tdata[CODE_W-1:0]),
    .square_i (square_q),
    .loc_o    (loc_a_d)
  );

  pf_locate u_lane_b (
    .letter_i (s_axis_tdata[2*CODE_W-1:CODE_W]),
    .square_i (square_q),
    .loc_o    (loc_b_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_a_q <= s_axis_tdata[CODE_W-1:0];
      raw_b_q <= s_axis_tdata[2*CODE_W-1:CODE_W];
      loc_a_q <= loc_a_d;
      loc_b_q <= loc_b_d;
    end
  end

  pf_merge u_merge (
    .raw_a_i  (raw_a_q),
    .raw_b_i  (raw_b_q),
    .loc_a_i  (loc_a_q),
    .loc_b_i  (loc_b_q),
    .square_i (square_q),
    .back_i   (back_q),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(DATA_W - 2*CODE_W){1'b0}}, res_q.second_out, res_q.first_out};
  assign m_axis_tuser  = res_q.both_found;

endmodule

// File: hdl/pf_checker.sv
// port-level checks of the playfair digraph cipher, bound to the top level
module pf_checker import pf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [0:0]        m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // with the output empty the input side never stalls
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // an accepted word reaches the output when the output side keeps taking words
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted word did not reach the output in time");

  // pad bits above the letter pair stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DATA_W-1:2*CODE_W] == '0)
    else $error("nonzero pad bits in result word");

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
